// File: hw/rtl/sirdig_pkg.sv
package sirdig_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_RADIX     = 2'd0;
    localparam logic [1:0] REG_CHARS_LOW = 2'd1;
    localparam logic [1:0] REG_CHARS_HI  = 2'd2;

    // configuration reset values
    localparam logic [4:0]  RADIX_RESET      = 5'd10;
    localparam logic [63:0] CHARS_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [63:0] CHARS_HIGH_RESET = 64'h6665_6463_6261_3938;

    localparam logic [4:0] RADIX_MIN  = 5'd2;
    localparam logic [4:0] RADIX_MAX  = 5'd16;
    localparam logic [7:0] MINUS_CHAR = 8'h2d;

    // quotient bits produced per divider cycle
    localparam int DIV_STEP = 4;

    // program counter width
    localparam int PC_W = 3;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_LOAD = 3'd1,
        OP_DIV  = 3'd2,
        OP_PUSH = 3'd3,
        OP_SIGN = 3'd4,
        OP_POP  = 3'd5
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEXT        = 3'd0,
        C_ALWAYS      = 3'd1,
        C_NO_INPUT    = 3'd2,
        C_DIV_MORE    = 3'd3,
        C_QUOT_NZ     = 3'd4,
        C_MORE_DIGITS = 3'd5
    } t_cond;

    // one control word
    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic             wait_out;
        logic [PC_W-1:0]  target;
    } t_uop;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic div_more;
        logic quot_nz;
        logic more_digits;
        logic out_free;
    } t_status;

    // program steps
    localparam logic [PC_W-1:0] PC_LOAD = 3'd0;
    localparam logic [PC_W-1:0] PC_DIV  = 3'd1;
    localparam logic [PC_W-1:0] PC_PUSH = 3'd2;
    localparam logic [PC_W-1:0] PC_SIGN = 3'd3;
    localparam logic [PC_W-1:0] PC_POP  = 3'd4;

    // control program: divide down pushing digits, then pop them out msd first
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop w;
        unique case (pc)
            PC_LOAD: w = '{op: OP_LOAD, cond: C_NO_INPUT,    wait_out: 1'b0, target: PC_LOAD};
            PC_DIV:  w = '{op: OP_DIV,  cond: C_DIV_MORE,    wait_out: 1'b0, target: PC_DIV};
            PC_PUSH: w = '{op: OP_PUSH, cond: C_QUOT_NZ,     wait_out: 1'b0, target: PC_DIV};
            PC_SIGN: w = '{op: OP_SIGN, cond: C_NEXT,        wait_out: 1'b1, target: PC_LOAD};
            PC_POP:  w = '{op: OP_POP,  cond: C_MORE_DIGITS, wait_out: 1'b1, target: PC_POP};
            default: w = '{op: OP_NOP,  cond: C_ALWAYS,      wait_out: 1'b0, target: PC_LOAD};
        endcase
        return w;
    endfunction

    // character for one digit value from the 16-entry table
    function automatic logic [7:0] digit_char(input logic [63:0] low, input logic [63:0] high,
                                              input logic [3:0] d);
        logic [127:0] tbl;
        tbl = {high, low};
        return tbl[{d, 3'b000} +: 8];
    endfunction

endpackage

// File: hw/rtl/sirdig_seq.sv
module sirdig_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sirdig_pkg::t_status i_status,
    output sirdig_pkg::t_op     o_op
);
    import sirdig_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uop            w_uop;
    logic            w_hold;
    logic            w_take;

    // fetch
    assign w_uop  = uop_rom(r_pc);
    assign w_hold = w_uop.wait_out && !i_status.out_free;

    // jump condition
    always_comb begin
        unique case (w_uop.cond)
            C_NEXT:        w_take = 1'b0;
            C_ALWAYS:      w_take = 1'b1;
            C_NO_INPUT:    w_take = !i_status.in_valid;
            C_DIV_MORE:    w_take = i_status.div_more;
            C_QUOT_NZ:     w_take = i_status.quot_nz;
            C_MORE_DIGITS: w_take = i_status.more_digits;
            default:       w_take = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        priority if (w_hold) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_uop.target;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    // a held step issues nothing
    assign o_op = w_hold ? OP_NOP : w_uop.op;

endmodule

// File: hw/rtl/sirdig_dp.sv
module sirdig_dp #(
    parameter int VALUE_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sirdig_pkg::t_op         i_op,
    output sirdig_pkg::t_status     o_status,
    input  logic                    i_in_valid,
    input  logic [VALUE_BITS-1:0]   i_value,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic [7:0]              o_character,
    output logic                    o_last,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [63:0]             i_cfg_data
);
    import sirdig_pkg::*;

    localparam int DIV_CYC = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int QW      = DIV_CYC * DIV_STEP;
    localparam int CNT_W   = $clog2(DIV_CYC);
    localparam int DEPTH   = VALUE_BITS;
    localparam int DEP_W   = $clog2(DEPTH + 1);

    // configuration
    logic [4:0]  r_radix;
    logic [63:0] r_chars_low;
    logic [63:0] r_chars_high;

    // working registers
    logic [QW-1:0]    r_quot;
    logic [3:0]       r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [3:0]       r_stack [DEPTH];
    logic [DEP_W-1:0] r_depth;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_char;
    logic        r_last;

    logic [4:0]            w_base;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_load;
    logic [3:0]            w_rs    [DIV_STEP+1];
    logic [QW-1:0]         w_qs    [DIV_STEP+1];
    logic [4:0]            w_trial [DIV_STEP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix      <= RADIX_RESET;
            r_chars_low  <= CHARS_LOW_RESET;
            r_chars_high <= CHARS_HIGH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RADIX:     r_radix      <= i_cfg_data[4:0];
                REG_CHARS_LOW: r_chars_low  <= i_cfg_data;
                REG_CHARS_HI:  r_chars_high <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // saturated radix
    always_comb begin
        priority if (r_radix < RADIX_MIN) begin
            w_base = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            w_base = RADIX_MAX;
        end else begin
            w_base = r_radix;
        end
    end

    // magnitude of the incoming value; most negative gives 2^(n-1)
    assign w_mag  = i_value[VALUE_BITS-1] ? (~i_value + VALUE_BITS'(1)) : i_value;
    assign w_load = (i_op == OP_LOAD) && i_in_valid;

    // restoring division by the radix, several quotient bits per cycle
    always_comb begin
        w_rs[0] = r_rem;
        w_qs[0] = r_quot;
        for (int k = 0; k < DIV_STEP; k++) begin
            w_trial[k] = {w_rs[k], w_qs[k][QW-1]};
            if (w_trial[k] >= w_base) begin
                w_rs[k+1] = 4'(w_trial[k] - w_base);
                w_qs[k+1] = {w_qs[k][QW-2:0], 1'b1};
            end else begin
                w_rs[k+1] = w_trial[k][3:0];
                w_qs[k+1] = {w_qs[k][QW-2:0], 1'b0};
            end
        end
    end

    // divider registers
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_quot <= QW'(w_mag);
            r_neg  <= i_value[VALUE_BITS-1];
        end else if (i_op == OP_DIV) begin
            r_quot <= w_qs[DIV_STEP];
        end
        if (w_load || i_op == OP_PUSH) begin
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_op == OP_DIV) begin
            r_rem <= w_rs[DIV_STEP];
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // digit stack, top at entry 0
    always_ff @(posedge i_clk) begin
        if (i_op == OP_PUSH) begin
            r_stack[0] <= r_rem;
            for (int i = 1; i < DEPTH; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (i_op == OP_POP) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (w_load) begin
            r_depth <= '0;
        end else if (i_op == OP_PUSH) begin
            r_depth <= r_depth + DEP_W'(1);
        end else if (i_op == OP_POP) begin
            r_depth <= r_depth - DEP_W'(1);
        end
    end

    // output register: loaded only when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_op == OP_SIGN && r_neg) || i_op == OP_POP) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_SIGN) begin
            r_char <= MINUS_CHAR;
            r_last <= 1'b0;
        end else if (i_op == OP_POP) begin
            r_char <= digit_char(r_chars_low, r_chars_high, r_stack[0]);
            r_last <= (r_depth == DEP_W'(1));
        end
    end

    // status for jumps
    assign o_status.in_valid    = i_in_valid;
    assign o_status.div_more    = (r_cnt != CNT_W'(DIV_CYC - 1));
    assign o_status.quot_nz     = (r_quot != '0);
    assign o_status.more_digits = (r_depth > DEP_W'(1));
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

// File: hw/rtl/signed_int_to_radix_digits.sv
// Writes one signed VALUE_BITS-bit integer out as characters: a minus sign
// first if the value is negative, then the digits of the magnitude in the
// configured radix (2..16, saturated), most significant first, each mapped
// through the 16-byte digit table; o_last marks the final character. The
// most negative value is written in full. A small control program drives a
// radix divider that yields 4 quotient bits per cycle; each digit is found
// by division and then pushed onto a digit stack, and the digits are then
// popped one per cycle while the output register is free. Input is
// taken only between numbers; a finished character waits in the output
// register.
module signed_int_to_radix_digits #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_character,
    output logic                  o_last,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [63:0]           i_cfg_data
);
    import sirdig_pkg::*;

    t_op     w_op;
    t_status w_status;

    // program sequencer
    sirdig_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_op     (w_op)
    );

    // divider, digit stack and output register
    sirdig_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .o_status    (w_status),
        .i_in_valid  (i_in_valid),
        .i_value     (i_value),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_character (o_character),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // new number only at the load step
    assign o_in_stall = (w_op != OP_LOAD);

    // a character is only written when the output register is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == OP_SIGN || w_op == OP_POP) |-> w_status.out_free)
        else $error("character written into occupied output register");

    // an accepted number moves the program off the load step
    a_leave_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("load step repeated after transfer");

    // no new number while characters of the current one remain
    a_mid_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> o_in_stall)
        else $error("input taken in the middle of a number");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sirdig_pkg::*;

    // one output character as it should appear at the output port
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_t;

    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 18;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_character;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_RADIX;
    logic [63:0] i_cfg_data = '0;

    // local copy of the configuration registers
    logic [4:0]  cfg_radix = RADIX_RESET;
    logic [63:0] cfg_chars_low = CHARS_LOW_RESET;
    logic [63:0] cfg_chars_high = CHARS_HIGH_RESET;

    logic [31:0] pending_values[$];
    char_t       expected_chars[$];
    int          send_idle_pct = 34;
    int          recv_stall_pct = 75;
    int          error_count = 0;
    int          quiet_cycles = 0;

    signed_int_to_radix_digits i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_character (o_character),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock generation
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // radix clamped into 2..16
    function automatic logic [31:0] clamped_radix();
        if (cfg_radix < RADIX_MIN) return 32'(RADIX_MIN);
        if (cfg_radix > RADIX_MAX) return 32'(RADIX_MAX);
        return 32'(cfg_radix);
    endfunction

    // queue the characters one number should produce
    function automatic void predict_chars(input logic [31:0] val);
        logic [31:0]  base;
        logic [31:0]  mag;
        logic [31:0]  place;
        logic [3:0]   d;
        logic [127:0] digit_table;
        char_t        c;
        base = clamped_radix();
        digit_table = {cfg_chars_high, cfg_chars_low};
        mag = val;
        if (val[31]) begin
            c.ch = MINUS_CHAR;
            c.last = 1'b0;
            expected_chars.push_back(c);
            mag = -val;
        end
        // leading place value, then walk down one digit per place
        place = 32'd1;
        while (mag / place >= base)
            place = place * base;
        while (place != 0) begin
            d = 4'((mag / place) % base);
            c.ch = digit_table[d * 8 +: 8];
            c.last = (place / base == 0);
            expected_chars.push_back(c);
            place = place / base;
        end
    endfunction

    // random value biased toward place-value boundaries and small numbers
    function automatic logic [31:0] random_value();
        logic [31:0] v;
        logic [31:0] p;
        logic [31:0] b;
        int          sel;
        sel = $urandom_range(99);
        if (sel < 45) begin
            v = $urandom;
        end else if (sel < 70) begin
            v = $urandom_range(2000) - 1000;
        end else if (sel < 88) begin
            b = clamped_radix();
            p = 32'd1;
            repeat ($urandom_range(31))
                if (p <= 32'h7fff_ffff / b) p = p * b;
            v = p - $urandom_range(1);
            if ($urandom_range(1)) v = -v;
        end else begin
            case ($urandom_range(4))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                2: v = 32'h8000_0001;
                3: v = 32'h0000_0000;
                default: v = 32'hffff_ffff;
            endcase
        end
        return v;
    endfunction

    // configuration register write, one cycle
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_RADIX:     cfg_radix = data[4:0];
            REG_CHARS_LOW: cfg_chars_low = data;
            REG_CHARS_HI:  cfg_chars_high = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // hold off until every queued number has been fully written out
    task automatic drain();
        while (pending_values.size() != 0 || i_in_valid || expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_value(input logic [31:0] v);
        pending_values.push_back(v);
    endtask

    // input driver: transfer on valid and not stall
    always @(posedge i_clk) begin : driver_proc
        logic sent;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            sent = i_in_valid && !o_in_stall;
            if (sent)
                predict_chars(i_value);
            if (!i_in_valid || sent) begin
                if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_value <= pending_values.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                    i_value <= $urandom;
                end
            end
        end
    end

    // output monitor and receiver stall
    always @(posedge i_clk) begin : monitor_proc
        char_t c;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character: expected none, actual %h last %b",
                             $time, o_character, o_last);
                    error_count++;
                end else begin
                    c = expected_chars.pop_front();
                    if (o_character !== c.ch) begin
                        $display("%0t: character: expected %h, actual %h",
                                 $time, c.ch, o_character);
                        error_count++;
                    end
                    if (o_last !== c.last) begin
                        $display("%0t: last: expected %b, actual %b", $time, c.last, o_last);
                        error_count++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("signed_int_to_radix_digits: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset configuration: decimal with the default table
        queue_value(32'd0);
        queue_value(32'd1);
        queue_value(32'hffff_ffff);
        queue_value(32'd9);
        queue_value(32'd10);
        queue_value(-32'd10);
        queue_value(32'h7fff_ffff);
        queue_value(32'h8000_0000);
        queue_value(32'd1000000000);
        queue_value(-32'd999999999);
        queue_value(32'h5555_5555);
        queue_value(32'haaaa_aaaa);
        drain();

        // hex with the default table
        write_reg(REG_RADIX, 64'(RADIX_MAX));
        @(negedge i_clk);
        queue_value(32'h7fff_ffff);
        queue_value(32'h8000_0000);
        queue_value(32'h0123_abcd);
        drain();

        // binary, most negative and largest values, all-zero low table
        write_reg(REG_RADIX, 64'(RADIX_MIN));
        write_reg(REG_CHARS_LOW, 64'h0);
        @(negedge i_clk);
        queue_value(32'h8000_0000);
        queue_value(32'h7fff_ffff);
        drain();

        // radix below two saturates to binary, all-ones low table
        write_reg(REG_RADIX, 64'd0);
        write_reg(REG_CHARS_LOW, '1);
        @(negedge i_clk);
        queue_value(32'hffff_ffff);
        drain();
        write_reg(REG_RADIX, 64'd1);
        @(negedge i_clk);
        queue_value(32'd5);
        drain();

        // radix above sixteen saturates to hex, all-zero high table
        write_reg(REG_RADIX, 64'd31);
        write_reg(REG_CHARS_HI, 64'h0);
        @(negedge i_clk);
        queue_value(32'hfedc_ba98);
        drain();
        write_reg(REG_RADIX, 64'd17);
        @(negedge i_clk);
        queue_value(32'd255);
        drain();

        // random part in three idling modes, new settings each phase
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 75 : 0;
            recv_stall_pct = (mode == 0) ? 75 : (mode == 1) ? 34 : 0;
            for (int ph = 0; ph < 4; ph++) begin
                if (ph == 0)
                    write_reg(REG_RADIX, 64'(mode == 1 ? RADIX_MAX : RADIX_MIN));
                else if ($urandom_range(4) == 0)
                    write_reg(REG_RADIX, 64'($urandom_range(31)));
                else
                    write_reg(REG_RADIX, 64'($urandom_range(16, 2)));
                write_reg(REG_CHARS_LOW, {$urandom, $urandom});
                write_reg(REG_CHARS_HI, {$urandom, $urandom});
                @(negedge i_clk);
                repeat (ITEMS_PER_PHASE) queue_value(random_value());
                drain();
            end
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("signed_int_to_radix_digits: match");
        end else begin
            $display("signed_int_to_radix_digits: mismatch");
        end
        $finish;
    end

endmodule
